// ----- sv/shsc_pkg.sv -----
// ----------------------------------------------------------------------------
// shsc_pkg: shared types and constants for the half/single converter
// Flag bit positions, lane result struct and conversion opcodes.
// ----------------------------------------------------------------------------
`default_nettype none
package shsc_pkg;
   localparam int unsigned MaxLanes = 4;
   localparam int unsigned FlagW    = 5;

   typedef enum logic {
      OP_H2S = 1'b0,
      OP_S2H = 1'b1
   } op_type;

   localparam logic [FlagW-1:0] FL_INV = 5'h01;
   localparam logic [FlagW-1:0] FL_OVF = 5'h02;
   localparam logic [FlagW-1:0] FL_UNF = 5'h04;
   localparam logic [FlagW-1:0] FL_INX = 5'h08;
   localparam logic [FlagW-1:0] FL_IDN = 5'h10;

   localparam logic [31:0] DEF_NAN_S = 32'h7FC0_0000;
   localparam logic [31:0] INF_S     = 32'h7F80_0000;
   localparam logic [15:0] DEF_NAN_H = 16'h7E00;
   localparam logic [15:0] INF_H     = 16'h7C00;
   localparam logic [15:0] MAX_AHP   = 16'h7FFF;

   typedef struct packed {
      logic [31:0]      res;
      logic [FlagW-1:0] flags;
   } lane_res_type;
endpackage
`default_nettype wire

// ----- sv/shsc_lane.sv -----
// ----------------------------------------------------------------------------
// shsc_lane: one conversion lane
// Converts half to single or single to half and reports the lane's flags.
// ----------------------------------------------------------------------------
`default_nettype none
module shsc_lane (
   input  wire logic                  alt_half,
   input  wire shsc_pkg::op_type      op,
   input  wire logic [31:0]           src,
   output shsc_pkg::lane_res_type     out
);
   import shsc_pkg::*;

   // half to single
   logic [31:0] h2s_res;
   logic [4:0]  h2s_fl;
   logic        hs;
   logic [4:0]  hex;
   logic [9:0]  hfr;
   logic [3:0]  lz;
   logic [9:0]  hnorm;

   always_comb begin
      hs  = src[15];
      hex = src[14:10];
      hfr = src[9:0];
      lz  = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (hfr[i]) lz = 4'(9 - i);
      end
      hnorm   = 10'(hfr << (lz + 4'd1));
      h2s_fl  = '0;
      h2s_res = {hs, 8'(hex) + 8'd112, hfr, 13'd0};
      if (hex == 5'h1F && !alt_half) begin
         if (hfr == 10'd0) begin
            h2s_res = {hs, 31'd0} | INF_S;
         end else begin
            h2s_res = DEF_NAN_S;
            if (!hfr[9]) h2s_fl = FL_INV;
         end
      end else if (hex == 5'd0) begin
         if (hfr == 10'd0) h2s_res = {hs, 31'd0};
         // leading one at bit 9-lz gives exponent 113-lz-1
         else h2s_res = {hs, 8'd112 - 8'(lz), hnorm, 13'd0};
      end
   end

   // single to half
   logic [15:0] s2h_res;
   logic [4:0]  s2h_fl;
   logic        ss;
   logic [7:0]  sex;
   logic [22:0] sfr;
   logic [23:0] m;
   logic [7:0]  sh;
   logic [47:0] shv;
   logic [10:0] mant;
   logic [11:0] mant_r;
   logic        inexact, up, rbit, sbit;
   logic [7:0]  bexp;

   always_comb begin
      ss = src[31];
      sex = src[30:23];
      sfr = src[22:0];
      m = {1'b1, sfr};
      s2h_fl = '0;
      s2h_res = '0;
      sh = '0; shv = '0; mant = '0; rbit = 1'b0; sbit = 1'b0;
      inexact = 1'b0; up = 1'b0; bexp = '0; mant_r = '0;
      if (sex == 8'hFF) begin
         if (sfr != 23'd0) begin
            if (alt_half || !sfr[22]) s2h_fl = FL_INV;
            s2h_res = alt_half ? {ss, 15'd0} : DEF_NAN_H;
         end else if (alt_half) begin
            s2h_fl = FL_INV;
            s2h_res = {ss, 15'd0} | MAX_AHP;
         end else begin
            s2h_res = {ss, 15'd0} | INF_H;
         end
      end else if (sex == 8'd0) begin
         if (sfr != 23'd0) s2h_fl = FL_IDN;
         s2h_res = {ss, 15'd0};
      end else begin
         if (sex > 8'd112) begin
            bexp = sex - 8'd112;
            mant = m[23:13];
            rbit = m[12];
            sbit = |m[11:0];
         end else begin
            sh = 8'd126 - sex;
            // shift the significand down, keeping 24 bits below the point
            if (sh >= 8'd40) shv = 48'd0;
            else shv = {m, 24'd0} >> sh;
            mant = shv[34:24];
            rbit = shv[23];
            sbit = |shv[22:0] || (sh >= 8'd40);
         end
         inexact = rbit || sbit;
         up = rbit && (sbit || mant[0]);
         if (sex <= 8'd112 && inexact) s2h_fl = s2h_fl | FL_UNF;
         mant_r = {1'b0, mant} + {11'd0, up};
         if (sex <= 8'd112) begin
            if (mant_r == 12'h400) bexp = 8'd1;
         end else if (mant_r == 12'h800) begin
            bexp = bexp + 8'd1;
            mant_r = mant_r >> 1;
         end
         if (alt_half && bexp >= 8'd32) begin
            s2h_fl = s2h_fl | FL_INV;
            s2h_res = {ss, 15'd0} | MAX_AHP;
         end else if (!alt_half && bexp >= 8'd31) begin
            s2h_fl = s2h_fl | FL_OVF | FL_INX;
            s2h_res = {ss, 15'd0} | INF_H;
         end else begin
            if (inexact) s2h_fl = s2h_fl | FL_INX;
            s2h_res = {ss, bexp[4:0], mant_r[9:0]};
         end
      end
   end

   always_comb begin
      if (op == OP_H2S) begin
         out.res   = h2s_res;
         out.flags = h2s_fl;
      end else begin
         out.res   = {16'd0, s2h_res};
         out.flags = s2h_fl;
      end
   end
endmodule
`default_nettype wire

// ----- sv/shsc_merge.sv -----
// ----------------------------------------------------------------------------
// shsc_merge: flag merge
// ORs the lane flags and updates the sticky register on each transfer.
// ----------------------------------------------------------------------------
`default_nettype none
module shsc_merge #(
   parameter int unsigned LANES = 4
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   load,
   input  wire logic                                   clear_sticky,
   input  wire shsc_pkg::lane_res_type [LANES-1:0]    lanes,
   output logic [shsc_pkg::FlagW-1:0]                  item_flags,
   output logic [shsc_pkg::FlagW-1:0]                  sticky_next
);
   import shsc_pkg::*;

   logic [FlagW-1:0] sticky_ff, sticky_in;

   always_comb begin
      item_flags = '0;
      for (int i = 0; i < LANES; i++) item_flags = item_flags | lanes[i].flags;
      sticky_in = (clear_sticky ? '0 : sticky_ff) | item_flags;
      sticky_next = sticky_in;
   end

   always_ff @(posedge clock) begin
      if (reset) sticky_ff <= '0;
      else if (load) sticky_ff <= sticky_in;
   end
endmodule
`default_nettype wire

// ----- sv/simd_half_single_convert.sv -----
// The result appears on rsp_* in the cycle after the input transfer.
// Throughput: one item per cycle unless stalled; all lanes convert in parallel.
// The output register is reloaded whenever it is empty or being taken.
// Reset clears alt_ff, the merge's sticky flags and the output valid.
// ----------------------------------------------------------------------------
// simd_half_single_convert: four-lane binary16/binary32 converter
// Parallel conversion lanes, a flag merge and a registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none
module simd_half_single_convert #(
   parameter int unsigned LANES = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_op,
   input  wire logic [31:0] req_src_lane0,
   input  wire logic [31:0] req_src_lane1,
   input  wire logic [31:0] req_src_lane2,
   input  wire logic [31:0] req_src_lane3,
   input  wire logic        req_clear_sticky,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_res_lane0,
   output logic [31:0]      rsp_res_lane1,
   output logic [31:0]      rsp_res_lane2,
   output logic [31:0]      rsp_res_lane3,
   output logic [4:0]       rsp_item_flags,
   output logic [4:0]       rsp_sticky_out,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [1:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import shsc_pkg::*;

   localparam logic [1:0] ADDR_ALT = 2'd0;

   logic alt_ff;
   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_ALT) ? {31'd0, alt_ff} : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) alt_ff <= 1'b0;
      else if (psel && penable && pwrite && paddr == ADDR_ALT) alt_ff <= pwdata[0];
   end

   logic [MaxLanes-1:0][31:0] src;
   assign src = {req_src_lane3, req_src_lane2, req_src_lane1, req_src_lane0};

   lane_res_type [LANES-1:0] lres;
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      shsc_lane u_lane (
         .alt_half (alt_ff),
         .op       (op_type'(req_op)),
         .src      (src[g]),
         .out      (lres[g])
      );
   end

   logic             load;
   logic [FlagW-1:0] flags, sticky_next;
   assign req_stall = rsp_valid && rsp_stall;
   assign load = req_valid && !req_stall;

   shsc_merge #(.LANES(LANES)) u_merge (
      .clock        (clock),
      .reset        (reset),
      .load         (load),
      .clear_sticky (req_clear_sticky),
      .lanes        (lres),
      .item_flags   (flags),
      .sticky_next  (sticky_next)
   );

   logic valid_ff;
   logic [MaxLanes-1:0][31:0] res_ff;
   logic [FlagW-1:0] flags_ff, sticky_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (!req_stall) valid_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < MaxLanes; i++)
            res_ff[i] <= (i < LANES) ? lres[i].res : 32'd0;
         flags_ff  <= flags;
         sticky_ff <= sticky_next;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_res_lane0  = res_ff[0];
   assign rsp_res_lane1  = res_ff[1];
   assign rsp_res_lane2  = res_ff[2];
   assign rsp_res_lane3  = res_ff[3];
   assign rsp_item_flags = flags_ff;
   assign rsp_sticky_out = sticky_ff;

`ifndef SYNTHESIS
   a_item_in_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_item_flags & ~rsp_sticky_out) == 5'd0))
      else $error("item flags missing from sticky flags");
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_sticky_out)))
      else $error("stalled result changed");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted item produced no result");
`endif
endmodule
`default_nettype wire

// ----- dv/simd_half_single_convert_test.sv -----
// ----------------------------------------------------------------------------
// simd_half_single_convert_test: self-checking bench for the lane converter
// Drives directed and random half/single conversions through bursty transfers
// with a stalling receiver, predicts lanes and flags, and compares every
// result in order. Runs under both half formats.
// ----------------------------------------------------------------------------
`default_nettype none
module simd_half_single_convert_test;
   timeunit 1ns;
   timeprecision 1ps;
   import shsc_pkg::*;

   typedef struct packed {
      op_type      op;
      logic [31:0] s0, s1, s2, s3;
      logic        clr;
   } conv_req_type;

   typedef struct packed {
      logic [31:0] r0, r1, r2, r3;
      logic [4:0]  fl;
      logic [4:0]  st;
   } conv_rsp_type;

   localparam logic [1:0] ADDR_AHP = 2'd0;
   localparam int unsigned CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   op_type req_op = OP_H2S;
   logic [31:0] req_src_lane0 = '0, req_src_lane1 = '0, req_src_lane2 = '0, req_src_lane3 = '0;
   logic req_clear_sticky = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [31:0] rsp_res_lane0, rsp_res_lane1, rsp_res_lane2, rsp_res_lane3;
   logic [4:0] rsp_item_flags, rsp_sticky_out;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   simd_half_single_convert dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_src_lane0(req_src_lane0), .req_src_lane1(req_src_lane1),
      .req_src_lane2(req_src_lane2), .req_src_lane3(req_src_lane3),
      .req_clear_sticky(req_clear_sticky),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_res_lane0(rsp_res_lane0), .rsp_res_lane1(rsp_res_lane1),
      .rsp_res_lane2(rsp_res_lane2), .rsp_res_lane3(rsp_res_lane3),
      .rsp_item_flags(rsp_item_flags), .rsp_sticky_out(rsp_sticky_out),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   conv_req_type pending_reqs[$];
   conv_rsp_type expected_rsps[$];
   logic      ahp_mode = 1'b0;
   logic [4:0] sticky_model = '0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   logic sender_hold = 1'b0;
   int unsigned burst_left = 0, gap_left = 0, stall_phase = 0;

   function automatic logic [31:0] half_to_single(input logic [15:0] h, inout logic [4:0] fl);
      logic [31:0] sgn;
      logic [4:0]  ex;
      logic [9:0]  fr;
      int unsigned w;
      sgn = {h[15], 31'd0};
      ex = h[14:10];
      fr = h[9:0];
      if (ex == 5'h1F && !ahp_mode) begin
         if (fr == 0) return sgn | INF_S;
         if (!fr[9]) fl |= FL_INV;
         return DEF_NAN_S;
      end
      if (ex == 0) begin
         if (fr == 0) return sgn;
         w = 0;
         for (int i = 0; i < 10; i++) if (fr[i]) w = i + 1;
         return sgn | ((w + 102) << 23) | ((32'(fr) << (24 - w)) & 32'h7F_FFFF);
      end
      return sgn | ((32'(ex) + 112) << 23) | (32'(fr) << 13);
   endfunction

   function automatic logic [15:0] single_to_half(input logic [31:0] f, inout logic [4:0] fl);
      logic [15:0] sgn;
      logic [7:0]  ex;
      logic [22:0] fr;
      logic [31:0] m, mant, rem, hlf, bexp;
      int unsigned sh;
      logic inx, up;
      sgn = {f[31], 15'd0};
      ex = f[30:23];
      fr = f[22:0];
      if (ex == 8'hFF) begin
         if (fr != 0) begin
            if (ahp_mode || !fr[22]) fl |= FL_INV;
            return ahp_mode ? sgn : DEF_NAN_H;
         end
         if (ahp_mode) begin
            fl |= FL_INV;
            return sgn | MAX_AHP;
         end
         return sgn | INF_H;
      end
      if (ex == 0) begin
         if (fr != 0) fl |= FL_IDN;
         return sgn;
      end
      m = {9'd1, fr};
      if (ex > 112) begin
         bexp = ex - 112;
         mant = m >> 13;
         rem = m & 32'h1FFF;
         inx = rem != 0;
         up = rem > 32'h1000 || (rem == 32'h1000 && mant[0]);
      end else begin
         bexp = 0;
         sh = 126 - ex;
         if (sh >= 32) begin
            mant = 0;
            inx = 1'b1;
            up = 1'b0;
         end else begin
            mant = m >> sh;
            rem = m & ((32'd1 << sh) - 1);
            hlf = 32'd1 << (sh - 1);
            inx = rem != 0;
            up = rem > hlf || (rem == hlf && mant[0]);
         end
         if (inx) fl |= FL_UNF;
      end
      if (up) begin
         mant++;
         if (mant == 32'h400) bexp = 1;
         if (mant == 32'h800) begin
            bexp++;
            mant >>= 1;
         end
      end
      if (ahp_mode) begin
         if (bexp >= 32) begin
            fl |= FL_INV;
            return sgn | MAX_AHP;
         end
      end else if (bexp >= 31) begin
         fl |= FL_OVF | FL_INX;
         return sgn | INF_H;
      end
      if (inx) fl |= FL_INX;
      return sgn | 16'(bexp << 10) | 16'(mant & 32'h3FF);
   endfunction

   function automatic logic [31:0] convert_lane(input op_type op, input logic [31:0] v,
                                                inout logic [4:0] fl);
      if (op == OP_H2S) return half_to_single(v[15:0], fl);
      return {16'd0, single_to_half(v, fl)};
   endfunction

   function automatic conv_rsp_type predict_conversion(input conv_req_type q);
      conv_rsp_type e;
      logic [4:0] fl;
      fl = '0;
      e.r0 = convert_lane(q.op, q.s0, fl);
      e.r1 = convert_lane(q.op, q.s1, fl);
      e.r2 = convert_lane(q.op, q.s2, fl);
      e.r3 = convert_lane(q.op, q.s3, fl);
      if (q.clr) sticky_model = '0;
      sticky_model |= fl;
      e.fl = fl;
      e.st = sticky_model;
      return e;
   endfunction

   // driver: bursts with random gaps; hold payload while stalled
   always @(posedge clock) begin
      conv_req_type nxt;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(predict_conversion(
               conv_req_type'{req_op, req_src_lane0, req_src_lane1, req_src_lane2,
                              req_src_lane3, req_clear_sticky}));
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) gap_left--;
            if (pending_reqs.size() != 0 && gap_left == 0 && !sender_hold) begin
               nxt = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_op <= nxt.op;
               req_src_lane0 <= nxt.s0;
               req_src_lane1 <= nxt.s1;
               req_src_lane2 <= nxt.s2;
               req_src_lane3 <= nxt.s3;
               req_clear_sticky <= nxt.clr;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 30);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern and result check
   always @(posedge clock) begin
      conv_rsp_type e;
      cycle_count++;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h %h %h %h %h %h",
                        $time, rsp_res_lane0, rsp_res_lane1, rsp_res_lane2, rsp_res_lane3,
                        rsp_item_flags, rsp_sticky_out);
               error_count++;
            end else begin
               e = expected_rsps.pop_front();
               if (e != conv_rsp_type'{rsp_res_lane0, rsp_res_lane1, rsp_res_lane2,
                                       rsp_res_lane3, rsp_item_flags, rsp_sticky_out}) begin
                  $display("%0t: mismatch, expected %h %h %h %h fl %h st %h",
                           $time, e.r0, e.r1, e.r2, e.r3, e.fl, e.st);
                  $display("%0t:           actual %h %h %h %h fl %h st %h",
                           $time, rsp_res_lane0, rsp_res_lane1, rsp_res_lane2,
                           rsp_res_lane3, rsp_item_flags, rsp_sticky_out);
                  error_count++;
               end
            end
         end
         stall_phase = (stall_phase + 1) % 200;
         if (stall_phase < 60) rsp_stall <= 1'b0;
         else if (stall_phase < 130) rsp_stall <= ($urandom_range(0, 3) == 0);
         else rsp_stall <= ($urandom_range(0, 1) == 0);
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simd_half_single_convert_test: done, errors");
         $finish;
      end
   end

   task automatic write_ahp(input logic val);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= ADDR_AHP;
      pwdata <= {31'd0, val};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      ahp_mode = val;
   endtask

   task automatic drain;
      wait (pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_single();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 9))
         0: v[30:23] = 8'hFF;
         1: v[30:23] = 8'h00;
         2, 3, 4: v[30:23] = 8'($urandom_range(100, 145));
         5: v[30:23] = 8'($urandom_range(140, 144));
         6: v[12:0] = 13'h1000;
         default: ;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] rand_half();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 5))
         0: v[14:10] = 5'h1F;
         1: v[14:10] = 5'h00;
         default: ;
      endcase
      return v;
   endfunction

   task automatic add_req(input op_type op, input logic [31:0] a, b, c, d, input logic clr);
      pending_reqs.push_back(conv_req_type'{op, a, b, c, d, clr});
   endtask

   task automatic add_random(input int unsigned n);
      op_type op;
      for (int unsigned i = 0; i < n; i++) begin
         op = op_type'($urandom_range(0, 1));
         if (op == OP_H2S)
            add_req(op, rand_half(), rand_half(), rand_half(), rand_half(),
                    $urandom_range(0, 7) == 0);
         else
            add_req(op, rand_single(), rand_single(), rand_single(), rand_single(),
                    $urandom_range(0, 7) == 0);
      end
   endtask

   task automatic add_directed;
      add_req(OP_H2S, 32'h0000_0000, 32'hFFFF_8000, 32'h0000_7C00, 32'h0000_FC00, 1'b0);
      add_req(OP_H2S, 32'h0000_7E00, 32'h0000_7C01, 32'h0000_0001, 32'h0000_83FF, 1'b0);
      add_req(OP_H2S, 32'h0000_7BFF, 32'hABCD_0400, 32'h0000_7FFF, 32'h0000_FFFF, 1'b1);
      add_req(OP_S2H, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001, 1'b1);
      add_req(OP_S2H, 32'h0000_0001, 32'h807F_FFFF, 32'h0000_0000, 32'h8000_0000, 1'b0);
      add_req(OP_S2H, 32'h477F_E000, 32'h477F_F000, 32'h4780_0000, 32'h7F7F_FFFF, 1'b0);
      add_req(OP_S2H, 32'h3880_0000, 32'h387F_FFFF, 32'h3380_0000, 32'h3300_0001, 1'b1);
      add_req(OP_S2H, 32'h0080_0000, 32'h3F80_1000, 32'h3F80_3000, 32'h3F80_0001, 1'b0);
      add_req(OP_S2H, 32'h3800_0000, 32'h33FF_FFFF, 32'h477F_EFFF, 32'hFFFF_FFFF, 1'b0);
      add_req(OP_H2S, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_3C00, 1'b0);
      add_req(OP_S2H, 32'h5555_5555, 32'hAAAA_AAAA, 32'h3F80_0000, 32'h4780_1000, 1'b0);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      add_directed();
      add_random(400);
      drain();
      write_ahp(1'b1);
      add_directed();
      add_random(400);
      // hold the sender until every result is back
      wait (pending_reqs.size() < 200);
      sender_hold = 1'b1;
      wait (!req_valid && expected_rsps.size() == 0);
      sender_hold = 1'b0;
      drain();
      write_ahp(1'b0);
      add_random(400);
      drain();
      write_ahp(1'b1);
      add_random(250);
      drain();
      write_ahp(1'b0);
      add_random(250);
      drain();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("simd_half_single_convert_test: done, clean");
      end else begin
         $display("simd_half_single_convert_test: done, errors");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ----- files.f -----
sv/shsc_pkg.sv
sv/shsc_lane.sv
sv/shsc_merge.sv
sv/simd_half_single_convert.sv
dv/simd_half_single_convert_test.sv
